FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/spp_pkg.sv
`timescale 1ns / 1ps

package spp_pkg;

   localparam int IDX_BITS         = 6;
   localparam int SEQ_BITS         = 6;
   localparam int DIM_IN_BITS      = 16;
   localparam int COORD_BITS       = 22;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int DIM_BITS_DEF     = 16;

   localparam logic [SEQ_BITS-1:0] SEQ_LAST = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_J,
      ST_SCAN_I,
      ST_WRITE_XY,
      ST_CHIP,
      ST_EMIT
   } spp_state_type;

   // Coordinate plus dimension, clamped to the largest coordinate.
   function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] c,
                                                     input logic [DIM_IN_BITS-1:0] d);
      logic [COORD_BITS:0] s;
      s = {1'b0, c} + (COORD_BITS+1)'(d);
      return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
   endfunction

endpackage

FILE: rtl/spp_ram.sv
`timescale 1ns / 1ps

module spp_ram #(
   parameter int WIDTH = 2 * spp_pkg::COORD_BITS,
   parameter int DEPTH = spp_pkg::MAX_BLOCKS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/spp_seq.sv
`timescale 1ns / 1ps

module spp_seq #(
   parameter int MAX_BLOCKS = spp_pkg::MAX_BLOCKS_DEF,
   parameter int DIM_BITS   = spp_pkg::DIM_BITS_DEF,
   localparam int ADDR_W = $clog2(MAX_BLOCKS),
   localparam int DW     = (DIM_BITS < spp_pkg::DIM_IN_BITS) ? DIM_BITS : spp_pkg::DIM_IN_BITS,
   localparam int GEO_W  = 2 * spp_pkg::SEQ_BITS + 2 * DW,
   localparam int XY_W   = 2 * spp_pkg::COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spp_pkg::IDX_BITS-1:0]      req_block_index,
   input  logic [spp_pkg::SEQ_BITS-1:0]      req_ps_position,
   input  logic [spp_pkg::SEQ_BITS-1:0]      req_ns_position,
   input  logic [spp_pkg::DIM_IN_BITS-1:0]   req_block_width,
   input  logic [spp_pkg::DIM_IN_BITS-1:0]   req_block_height,
   input  logic                              req_last_block,
   output logic                              geo_we,
   output logic [ADDR_W-1:0]                 geo_waddr,
   output logic [GEO_W-1:0]                  geo_wdata,
   input  logic [GEO_W-1:0]                  geo_rdata,
   output logic                              xy_we,
   output logic [ADDR_W-1:0]                 xy_waddr,
   output logic [XY_W-1:0]                   xy_wdata,
   input  logic [XY_W-1:0]                   xy_rdata,
   output logic [ADDR_W-1:0]                 mem_raddr,
   output logic                              rsp_valid,
   output logic [spp_pkg::IDX_BITS-1:0]      rsp_out_index,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_x_coord,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_y_coord,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_chip_width,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_chip_height,
   output logic                              rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int SB    = spp_pkg::SEQ_BITS;
   localparam int CB    = spp_pkg::COORD_BITS;
   localparam int DIN   = spp_pkg::DIM_IN_BITS;
   localparam int H_LO  = 0;
   localparam int W_LO  = DW;
   localparam int NS_LO = 2 * DW;
   localparam int PS_LO = 2 * DW + SB;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_BLOCKS - 1);

   spp_pkg::spp_state_type state_ff, state_in;

   logic [SB-1:0]         v_ff, v_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  all_ff, all_in;
   logic                  dv_ff, dv_in;
   logic [ADDR_W-1:0]     didx_ff, didx_in;
   logic [ADDR_W-1:0]     tgt_ff, tgt_in;
   logic [SB-1:0]         tgt_ps_ff, tgt_ps_in;
   logic [CB-1:0]         bx_ff, bx_in, by_ff, by_in;
   logic [CB-1:0]         cw_ff, cw_in, ch_ff, ch_in;
   logic [MAX_BLOCKS-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [CB-1:0]         rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  idx_ok;
   logic [ADDR_W-1:0]     ld_addr;
   logic                  issue_en;
   logic                  last_data;
   logic                  data_loaded;
   logic                  hit_j;
   logic                  i_before;
   logic                  v_last;
   logic                  tgt_last;
   logic [SB-1:0]         g_ps, g_ns;
   logic [DW-1:0]         g_w, g_h;
   logic [CB-1:0]         x_i, y_i, sx, sy;

   assign busy    = (state_ff != spp_pkg::ST_IDLE) || rsp_valid_ff;
   assign accept  = start && !busy;
   assign idx_ok  = ((spp_pkg::IDX_BITS+1)'(req_block_index) <
                     (spp_pkg::IDX_BITS+1)'(MAX_BLOCKS));
   assign ld_addr = req_block_index[ADDR_W-1:0];

   assign geo_we    = accept && idx_ok;
   assign geo_waddr = ld_addr;
   assign geo_wdata = {req_ps_position, req_ns_position,
                       req_block_width[DW-1:0], req_block_height[DW-1:0]};

   assign g_ps = geo_rdata[PS_LO +: SB];
   assign g_ns = geo_rdata[NS_LO +: SB];
   assign g_w  = geo_rdata[W_LO +: DW];
   assign g_h  = geo_rdata[H_LO +: DW];
   assign x_i  = xy_rdata[CB +: CB];
   assign y_i  = xy_rdata[0 +: CB];
   assign sx   = spp_pkg::sat_add(x_i, DIN'(g_w));
   assign sy   = spp_pkg::sat_add(y_i, DIN'(g_h));

   assign issue_en = ((state_ff == spp_pkg::ST_SCAN_J) || (state_ff == spp_pkg::ST_SCAN_I) ||
                      (state_ff == spp_pkg::ST_CHIP) || (state_ff == spp_pkg::ST_EMIT)) &&
                     !all_ff;
   assign last_data   = dv_ff && (didx_ff == ADDR_LAST);
   assign data_loaded = dv_ff && loaded_ff[didx_ff];
   assign hit_j       = data_loaded && (g_ns == v_ff);
   assign i_before    = data_loaded && (g_ns < v_ff);
   assign v_last      = (v_ff == spp_pkg::SEQ_LAST);
   assign tgt_last    = (tgt_ff == ADDR_LAST);

   assign mem_raddr = addr_ff;
   assign xy_we     = (state_ff == spp_pkg::ST_WRITE_XY);
   assign xy_waddr  = tgt_ff;
   assign xy_wdata  = {bx_ff, by_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spp_pkg::ST_IDLE: begin
            if (accept && req_last_block) begin
               state_in = spp_pkg::ST_SCAN_J;
            end
         end
         spp_pkg::ST_SCAN_J: begin
            if (hit_j) begin
               state_in = spp_pkg::ST_SCAN_I;
            end else if (last_data && v_last) begin
               state_in = spp_pkg::ST_CHIP;
            end
         end
         spp_pkg::ST_SCAN_I: begin
            if (last_data) begin
               state_in = spp_pkg::ST_WRITE_XY;
            end
         end
         spp_pkg::ST_WRITE_XY: begin
            state_in = (tgt_last && v_last) ? spp_pkg::ST_CHIP : spp_pkg::ST_SCAN_J;
         end
         spp_pkg::ST_CHIP: begin
            if (last_data) begin
               state_in = spp_pkg::ST_EMIT;
            end
         end
         spp_pkg::ST_EMIT: begin
            if (last_data) begin
               state_in = spp_pkg::ST_IDLE;
            end
         end
         default: state_in = spp_pkg::ST_IDLE;
      endcase
   end

   // Scan addressing and datapath.
   always_comb begin
      v_in         = v_ff;
      addr_in      = addr_ff;
      all_in       = all_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      tgt_in       = tgt_ff;
      tgt_ps_in    = tgt_ps_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      cw_in        = cw_ff;
      ch_in        = ch_ff;
      loaded_in    = loaded_ff;
      count_in     = count_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;

      if (issue_en) begin
         addr_in = ADDR_W'(addr_ff + 1'b1);
         dv_in   = 1'b1;
         didx_in = addr_ff;
         if (addr_ff == ADDR_LAST) begin
            all_in = 1'b1;
         end
      end

      unique case (state_ff)
         spp_pkg::ST_IDLE: begin
            if (accept) begin
               if (idx_ok && !loaded_ff[ld_addr]) begin
                  loaded_in[ld_addr] = 1'b1;
                  count_in           = CNT_W'(count_ff + 1'b1);
               end
               if (req_last_block) begin
                  v_in    = '0;
                  addr_in = '0;
                  all_in  = 1'b0;
                  cw_in   = '0;
                  ch_in   = '0;
               end
            end
         end
         spp_pkg::ST_SCAN_J: begin
            if (hit_j) begin
               tgt_in    = didx_ff;
               tgt_ps_in = g_ps;
               bx_in     = '0;
               by_in     = '0;
               addr_in   = '0;
               all_in    = 1'b0;
               dv_in     = 1'b0;
            end else if (last_data) begin
               if (!v_last) begin
                  v_in = SB'(v_ff + 1'b1);
               end
               addr_in = '0;
               all_in  = 1'b0;
               dv_in   = 1'b0;
            end
         end
         spp_pkg::ST_SCAN_I: begin
            if (i_before) begin
               if (g_ps < tgt_ps_ff) begin
                  if (sx > bx_ff) begin
                     bx_in = sx;
                  end
               end else if (g_ps > tgt_ps_ff) begin
                  if (sy > by_ff) begin
                     by_in = sy;
                  end
               end
            end
         end
         spp_pkg::ST_WRITE_XY: begin
            all_in = 1'b0;
            if (tgt_last) begin
               addr_in = '0;
               if (!v_last) begin
                  v_in = SB'(v_ff + 1'b1);
               end
            end else begin
               addr_in = ADDR_W'(tgt_ff + 1'b1);
            end
         end
         spp_pkg::ST_CHIP: begin
            if (data_loaded) begin
               if (sx > cw_ff) begin
                  cw_in = sx;
               end
               if (sy > ch_ff) begin
                  ch_in = sy;
               end
            end
            if (last_data) begin
               addr_in     = '0;
               all_in      = 1'b0;
               dv_in       = 1'b0;
               emit_cnt_in = '0;
            end
         end
         spp_pkg::ST_EMIT: begin
            if (data_loaded) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = didx_ff;
               rsp_x_in     = x_i;
               rsp_y_in     = y_i;
               rsp_last_in  = (CNT_W'(emit_cnt_ff + 1'b1) == count_ff);
               emit_cnt_in  = CNT_W'(emit_cnt_ff + 1'b1);
            end
            if (last_data) begin
               loaded_in = '0;
               count_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spp_pkg::ST_IDLE;
         all_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         loaded_ff    <= '0;
         count_ff     <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         all_ff       <= all_in;
         dv_ff        <= dv_in;
         loaded_ff    <= loaded_in;
         count_ff     <= count_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      addr_ff     <= addr_in;
      didx_ff     <= didx_in;
      tgt_ff      <= tgt_in;
      tgt_ps_ff   <= tgt_ps_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = spp_pkg::IDX_BITS'(rsp_idx_ff);
   assign rsp_x_coord     = rsp_x_ff;
   assign rsp_y_coord     = rsp_y_ff;
   assign rsp_chip_width  = cw_ff;
   assign rsp_chip_height = ch_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: rtl/sequence_pair_placement_core.sv
// Loading item: the block is ready for the next item in the next cycle.
// Last item: placement is paced by the shared read address that every scan walks through.
// Results then leave at most one per cycle; the receiver cannot stall them.
// Reset (synchronous, active high) empties the batch; the memories are not cleared.
`timescale 1ns / 1ps

module sequence_pair_placement_core #(
   parameter int MAX_BLOCKS = spp_pkg::MAX_BLOCKS_DEF,
   parameter int DIM_BITS   = spp_pkg::DIM_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spp_pkg::IDX_BITS-1:0]      req_block_index,
   input  logic [spp_pkg::SEQ_BITS-1:0]      req_ps_position,
   input  logic [spp_pkg::SEQ_BITS-1:0]      req_ns_position,
   input  logic [spp_pkg::DIM_IN_BITS-1:0]   req_block_width,
   input  logic [spp_pkg::DIM_IN_BITS-1:0]   req_block_height,
   input  logic                              req_last_block,
   output logic                              rsp_valid,
   output logic [spp_pkg::IDX_BITS-1:0]      rsp_out_index,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_x_coord,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_y_coord,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_chip_width,
   output logic [spp_pkg::COORD_BITS-1:0]    rsp_chip_height,
   output logic                              rsp_last_result
);

   // The block geometry (both sequence positions, width and height) lives in one memory,
   // written as each item with an index below MAX_BLOCKS is accepted. Only the low bits
   // of a dimension that the DIM_BITS setting keeps are stored.
   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int DW     = (DIM_BITS < spp_pkg::DIM_IN_BITS) ? DIM_BITS : spp_pkg::DIM_IN_BITS;
   localparam int GEO_W  = 2 * spp_pkg::SEQ_BITS + 2 * DW;
   localparam int XY_W   = 2 * spp_pkg::COORD_BITS;

   logic              geo_we;
   logic [ADDR_W-1:0] geo_waddr;
   logic [GEO_W-1:0]  geo_wdata;
   logic [GEO_W-1:0]  geo_rdata;
   logic              xy_we;
   logic [ADDR_W-1:0] xy_waddr;
   logic [XY_W-1:0]   xy_wdata;
   logic [XY_W-1:0]   xy_rdata;
   logic [ADDR_W-1:0] mem_raddr;

   // The sequencer places blocks in order of their negative-sequence position. For each
   // position value it sweeps the block memory; every loaded block found at that value is
   // placed by a second sweep over all blocks earlier in the negative sequence, whose
   // coordinates are therefore already final. The longest left and below paths are
   // collected one block per cycle and written back to the coordinate memory in a state of
   // their own, so a read never overlaps a write to the same entry.
   // A further sweep finds the chip extent and a last one sends out the results in
   // ascending block order. A valid bit per entry, held in flip-flops, tells which
   // entries belong to the present batch.
   spp_seq #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .DIM_BITS   (DIM_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_block_index  (req_block_index),
      .req_ps_position  (req_ps_position),
      .req_ns_position  (req_ns_position),
      .req_block_width  (req_block_width),
      .req_block_height (req_block_height),
      .req_last_block   (req_last_block),
      .geo_we           (geo_we),
      .geo_waddr        (geo_waddr),
      .geo_wdata        (geo_wdata),
      .geo_rdata        (geo_rdata),
      .xy_we            (xy_we),
      .xy_waddr         (xy_waddr),
      .xy_wdata         (xy_wdata),
      .xy_rdata         (xy_rdata),
      .mem_raddr        (mem_raddr),
      .rsp_valid        (rsp_valid),
      .rsp_out_index    (rsp_out_index),
      .rsp_x_coord      (rsp_x_coord),
      .rsp_y_coord      (rsp_y_coord),
      .rsp_chip_width   (rsp_chip_width),
      .rsp_chip_height  (rsp_chip_height),
      .rsp_last_result  (rsp_last_result)
   );

   // Both memories are read at the same address, so one sweep sees a block's geometry and
   // its coordinates together, in the cycle after the address is issued.
   spp_ram #(
      .WIDTH (GEO_W),
      .DEPTH (MAX_BLOCKS)
   ) u_geo_ram (
      .clock (clock),
      .we    (geo_we),
      .waddr (geo_waddr),
      .wdata (geo_wdata),
      .raddr (mem_raddr),
      .rdata (geo_rdata)
   );

   spp_ram #(
      .WIDTH (XY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_xy_ram (
      .clock (clock),
      .we    (xy_we),
      .waddr (xy_waddr),
      .wdata (xy_wdata),
      .raddr (mem_raddr),
      .rdata (xy_rdata)
   );

endmodule

FILE: rtl/spp_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spp_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_block,
   input logic rsp_valid,
   input logic rsp_last_result
);

   // A loading item leaves the block free again at once.
   `SPP_ASSERT_NXT(a_load_free, clock, reset, start && !busy && !req_last_block, !busy)

   // The final item starts placement, and no result can appear in the next cycle.
   `SPP_ASSERT_NXT(a_place_busy, clock, reset, start && !busy && req_last_block, busy && !rsp_valid)

   // The final result of a batch is never followed directly by another one.
   `SPP_ASSERT_NXT(a_last_ends, clock, reset, rsp_valid && rsp_last_result, !rsp_valid)

   // Before the final result more results are still to come.
   `SPP_ASSERT_NXT(a_more_to_come, clock, reset, rsp_valid && !rsp_last_result, busy)

endmodule

bind sequence_pair_placement_core spp_chk u_spp_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_last_block  (req_last_block),
   .rsp_valid       (rsp_valid),
   .rsp_last_result (rsp_last_result)
);
